// ===== hw/rtl/text_encoding_detector_assert.svh =====
// Assertion macros used by the checker file.
// The properties sample on clk_i and are off while rst_ni is low.
`ifndef TEXT_ENCODING_DETECTOR_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define TED_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ted_pkg.sv =====
`default_nettype none

package ted_pkg;

  // Verdict codes
  typedef enum logic [2:0] {
    EncUtf8Mark  = 3'd0,
    EncUtf16Le   = 3'd1,
    EncUtf16Be   = 3'd2,
    EncUtf8Plain = 3'd3,
    EncAnsi      = 3'd4
  } encoding_e;

  // Byte order mark bytes
  localparam logic [7:0] BomUtf8B0 = 8'hEF;
  localparam logic [7:0] BomUtf8B1 = 8'hBB;
  localparam logic [7:0] BomUtf8B2 = 8'hBF;
  localparam logic [7:0] BomFf     = 8'hFF;
  localparam logic [7:0] BomFe     = 8'hFE;

  // UTF-8 lead and continuation tags
  localparam logic [7:0] AsciiMax = 8'h7F;
  localparam logic [2:0] Lead2Tag = 3'h6;
  localparam logic [3:0] Lead3Tag = 4'hE;
  localparam logic [4:0] Lead4Tag = 5'h1E;
  localparam logic [1:0] ContTag  = 2'h2;

  // Head capture depth and mark lengths
  localparam logic [1:0] HeadFull    = 2'd3;
  localparam logic [1:0] MarkLenUtf8 = 2'd3;
  localparam logic [1:0] MarkLen16   = 2'd2;
  localparam logic [1:0] MarkLenNone = 2'd0;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    encoding_e  encoding;
    logic [1:0] mark_length;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ted_scan.sv =====
`default_nettype none

module ted_scan
  import ted_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire in_beat_t  beat_i,
  output out_beat_t      verdict_o
);

  logic [2:0][7:0] head_bytes_q, head_bytes_d, head_bytes_upd;
  logic [1:0]      head_count_q, head_count_d, head_count_upd;
  logic [1:0]      pending_q, pending_d, pending_upd;
  logic            failed_q, failed_d, failed_upd;
  logic [7:0]      b;

  assign b = beat_i.byte_value;

  // Capture head bytes and run the UTF-8 check on one byte
  always_comb begin
    head_bytes_upd = head_bytes_q;
    head_count_upd = head_count_q;
    pending_upd    = pending_q;
    failed_upd     = failed_q;
    if (beat_i.has_byte) begin
      if (head_count_q != HeadFull) begin
        head_bytes_upd[head_count_q] = b;
        head_count_upd               = head_count_q + 2'd1;
      end
      if (!failed_q) begin
        if (pending_q != 2'd0) begin
          if (b[7:6] != ContTag) begin
            failed_upd = 1'b1;
          end else begin
            pending_upd = pending_q - 2'd1;
          end
        end else if (b <= AsciiMax) begin
          pending_upd = 2'd0;
        end else if (b[7:5] == Lead2Tag) begin
          pending_upd = 2'd1;
        end else if (b[7:4] == Lead3Tag) begin
          pending_upd = 2'd2;
        end else if (b[7:3] == Lead4Tag) begin
          pending_upd = 2'd3;
        end else begin
          failed_upd = 1'b1;
        end
      end
    end
  end

  // Decide the verdict from the updated state
  always_comb begin
    if (head_count_upd == HeadFull && head_bytes_upd[0] == BomUtf8B0 &&
        head_bytes_upd[1] == BomUtf8B1 && head_bytes_upd[2] == BomUtf8B2) begin
      verdict_o.encoding    = EncUtf8Mark;
      verdict_o.mark_length = MarkLenUtf8;
    end else if (head_count_upd >= 2'd2 && head_bytes_upd[0] == BomFf &&
                 head_bytes_upd[1] == BomFe) begin
      verdict_o.encoding    = EncUtf16Le;
      verdict_o.mark_length = MarkLen16;
    end else if (head_count_upd >= 2'd2 && head_bytes_upd[0] == BomFe &&
                 head_bytes_upd[1] == BomFf) begin
      verdict_o.encoding    = EncUtf16Be;
      verdict_o.mark_length = MarkLen16;
    end else if (head_count_upd != 2'd0 && !failed_upd && pending_upd == 2'd0) begin
      verdict_o.encoding    = EncUtf8Plain;
      verdict_o.mark_length = MarkLenNone;
    end else begin
      verdict_o.encoding    = EncAnsi;
      verdict_o.mark_length = MarkLenNone;
    end
  end

  // Clear everything after the last beat so the next file starts fresh
  always_comb begin
    if (beat_i.last) begin
      head_bytes_d = '0;
      head_count_d = '0;
      pending_d    = '0;
      failed_d     = 1'b0;
    end else begin
      head_bytes_d = head_bytes_upd;
      head_count_d = head_count_upd;
      pending_d    = pending_upd;
      failed_d     = failed_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_bytes_q <= '0;
      head_count_q <= '0;
      pending_q    <= '0;
      failed_q     <= 1'b0;
    end else if (advance_i) begin
      head_bytes_q <= head_bytes_d;
      head_count_q <= head_count_d;
      pending_q    <= pending_d;
      failed_q     <= failed_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_encoding_detector.sv =====
`default_nettype none

// Encoding detector for one file streamed a byte per beat. The block takes one
// beat every cycle while in_ready_o is high; a beat lands in an input
// register, is scanned in the next cycle, and a last beat's verdict is
// registered onto out_o. in_ready_o drops only while a verdict sits unaccepted
// in the output register and another last beat waits behind it in the input
// register; beats that are not last keep flowing under a stalled verdict.
// Detection state clears itself after each verdict, so files may follow each
// other back to back. A beat with has_byte low and last low is dropped.
module text_encoding_detector
  import ted_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_o
);

  logic      in_valid_q;
  in_beat_t  in_q;
  logic      out_valid_q;
  out_beat_t out_q;
  out_beat_t verdict;
  logic      advance;
  logic      emit;

  // Advance the held beat unless it is a verdict blocked by the output
  assign advance    = in_valid_q && (!in_q.last || !out_valid_q || out_ready_i);
  assign emit       = advance && in_q.last;
  assign in_ready_o = !in_valid_q || advance;

  ted_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .beat_i    (in_q),
    .verdict_o (verdict)
  );

  // Track valid flags of input and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
    if (emit) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ted_checker.sv =====
`default_nettype none

`include "text_encoding_detector_assert.svh"

module ted_checker
  import ted_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_beat_t  in_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_o
);

  // Hold a stalled verdict
  `TED_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o), "verdict changed while stalled")

  // Stall input only behind a pending verdict
  `TED_ASSERT_IMPLIES(a_stall_cause, !in_ready_o, out_valid_o, "input stalled with no verdict pending")

  // A fresh verdict comes from an accepted last beat via the input and output registers
  `TED_ASSERT_IMPLIES(a_verdict_src, $rose(out_valid_o), $past(in_valid_i && in_ready_o && in_i.last, 2), "verdict without a last beat")

  // Mark length of three goes with the UTF-8 mark verdict only
  `TED_ASSERT_IMPLIES(a_mark_len, out_valid_o, (out_o.encoding == EncUtf8Mark) == (out_o.mark_length == MarkLenUtf8), "mark length disagrees with encoding")

endmodule

bind text_encoding_detector ted_checker u_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
  import ted_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandBeats  = 1350;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 8;
  localparam int unsigned MaxReports = 20;
  localparam int unsigned DirRows    = 25;

  // One row of the directed table; want fields matter only when typed is set
  typedef struct packed {
    logic [7:0] b;
    logic       has;
    logic       last;
    logic       typed;
    encoding_e  enc;
    logic [1:0] mark;
  } dir_row_t;

  typedef enum logic [1:0] {
    SinkSteady,
    SinkChoppy,
    SinkBursty
  } sink_mode_e;

  localparam dir_row_t DirTbl [DirRows] = '{
    // empty file: end marker only
    '{8'h00, 1'b0, 1'b1, 1'b1, EncAnsi, MarkLenNone},
    // dropped beat, then UTF-8 mark and one character
    '{8'h55, 1'b0, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{BomUtf8B0, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{BomUtf8B1, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{BomUtf8B2, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'h41, 1'b1, 1'b1, 1'b1, EncUtf8Mark, MarkLenUtf8},
    // UTF-16 marks alone
    '{BomFf, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{BomFe, 1'b1, 1'b1, 1'b1, EncUtf16Le, MarkLen16},
    '{BomFe, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{BomFf, 1'b1, 1'b1, 1'b1, EncUtf16Be, MarkLen16},
    // cut-off UTF-8 mark: no mark, truncated sequence
    '{BomUtf8B0, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{BomUtf8B1, 1'b1, 1'b1, 1'b1, EncAnsi, MarkLenNone},
    // single zero byte
    '{8'h00, 1'b1, 1'b1, 1'b1, EncUtf8Plain, MarkLenNone},
    // 2, 3 and 4 byte characters, closed by an end marker
    '{8'hC3, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'hA9, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'hE2, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'h82, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'hAC, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'hF0, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'h9F, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'h98, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'h80, 1'b1, 1'b0, 1'b0, EncAnsi, MarkLenNone},
    '{8'hFF, 1'b0, 1'b1, 1'b0, EncAnsi, MarkLenNone},
    // bad lead alone, stray continuation alone
    '{8'hFF, 1'b1, 1'b1, 1'b1, EncAnsi, MarkLenNone},
    '{8'h80, 1'b1, 1'b1, 1'b1, EncAnsi, MarkLenNone}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_beat_t  in_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_beat_t out_o;

  // Detector image kept by the testbench
  logic [7:0] head_q [3];
  logic [1:0] head_cnt;
  logic [1:0] owed_cont;
  logic       utf8_bad;

  out_beat_t   verdict_q [$];
  logic [7:0]  file_q [$];
  int unsigned beats_sent;
  int unsigned files_sent;
  int unsigned burst_left;
  int unsigned err_cnt;
  int unsigned enc_seen [5];
  int unsigned cycle_cnt;
  int unsigned hold_left;
  sink_mode_e  sink_mode;

  text_encoding_detector u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Add one byte at the end of the file being built
  function automatic void append_byte(input logic [7:0] v);
    file_q.insert(file_q.size(), v);
  endfunction

  // Add one expected verdict behind the ones already waiting
  function automatic void append_verdict(input out_beat_t v);
    verdict_q.insert(verdict_q.size(), v);
  endfunction

  // Clear the detector image back to the start of a file
  function automatic void clear_scan();
    head_q   = '{8'h00, 8'h00, 8'h00};
    head_cnt = 2'd0;
    owed_cont = 2'd0;
    utf8_bad = 1'b0;
  endfunction

  // Advance the detector image by one accepted beat; queue a verdict on last
  function automatic void scan_beat(input in_beat_t b, input logic typed,
                                    input out_beat_t want);
    out_beat_t v;
    logic [7:0] c;
    c = b.byte_value;
    beats_sent++;
    if (b.has_byte) begin
      if (head_cnt < HeadFull) begin
        head_q[head_cnt] = c;
        head_cnt++;
      end
      if (!utf8_bad) begin
        if (owed_cont != 2'd0) begin
          if (c[7:6] != ContTag) utf8_bad = 1'b1;
          else owed_cont--;
        end else if (c > AsciiMax) begin
          if (c[7:5] == Lead2Tag) owed_cont = 2'd1;
          else if (c[7:4] == Lead3Tag) owed_cont = 2'd2;
          else if (c[7:3] == Lead4Tag) owed_cont = 2'd3;
          else utf8_bad = 1'b1;
        end
      end
    end
    if (b.last) begin
      if (head_cnt == HeadFull && head_q[0] == BomUtf8B0 && head_q[1] == BomUtf8B1 &&
          head_q[2] == BomUtf8B2) begin
        v.encoding = EncUtf8Mark;
        v.mark_length = MarkLenUtf8;
      end else if (head_cnt >= 2'd2 && head_q[0] == BomFf && head_q[1] == BomFe) begin
        v.encoding = EncUtf16Le;
        v.mark_length = MarkLen16;
      end else if (head_cnt >= 2'd2 && head_q[0] == BomFe && head_q[1] == BomFf) begin
        v.encoding = EncUtf16Be;
        v.mark_length = MarkLen16;
      end else if (head_cnt != 2'd0 && !utf8_bad && owed_cont == 2'd0) begin
        v.encoding = EncUtf8Plain;
        v.mark_length = MarkLenNone;
      end else begin
        v.encoding = EncAnsi;
        v.mark_length = MarkLenNone;
      end
      append_verdict(typed ? want : v);
      files_sent++;
      clear_scan();
    end
  endfunction

  // Offer one beat, with burst gaps in front, and hold it until accepted
  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    scan_beat(b, typed, want);
  endtask

  // Stop offering until every queued verdict has been taken
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
    burst_left = $urandom_range(1, 24);
  endtask

  // Append one UTF-8 character of len bytes, keeping only the first keep bytes
  task automatic add_char(input int unsigned len, input int unsigned keep);
    logic [7:0] seq [4];
    case (len)
      1: seq[0] = {1'b0, 7'($urandom())};
      2: seq[0] = {Lead2Tag, 5'($urandom())};
      3: seq[0] = {Lead3Tag, 4'($urandom())};
      default: seq[0] = {Lead4Tag, 3'($urandom())};
    endcase
    for (int i = 1; i < 4; i++) seq[i] = {ContTag, 6'($urandom())};
    for (int i = 0; i < keep && i < len; i++) append_byte(seq[i]);
  endtask

  // Stimulus
  initial begin
    in_beat_t    beat;
    out_beat_t   none;
    int unsigned kind;
    int unsigned n;
    int unsigned len;
    logic        marker;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    none        = '{encoding: EncAnsi, mark_length: MarkLenNone};
    beats_sent  = 0;
    files_sent  = 0;
    burst_left  = 0;
    clear_scan();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < DirRows; r++) begin
      beat.byte_value = DirTbl[r].b;
      beat.has_byte   = DirTbl[r].has;
      beat.last       = DirTbl[r].last;
      send_beat(beat, DirTbl[r].typed,
                '{encoding: DirTbl[r].enc, mark_length: DirTbl[r].mark});
    end
    hold_until_drained();

    // Random files, mostly well formed
    while (beats_sent < RandBeats + DirRows) begin
      file_q.delete();
      kind = $urandom_range(0, 11);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 10);
      case (kind)
        0: ;
        1: begin
          file_q = '{BomUtf8B0, BomUtf8B1, BomUtf8B2};
          repeat (n) add_char($urandom_range(1, 4), 4);
        end
        2: begin
          file_q = '{BomFf, BomFe};
          repeat (n) append_byte(8'($urandom()));
        end
        3: begin
          file_q = '{BomFe, BomFf};
          repeat (n) append_byte(8'($urandom()));
        end
        4, 5, 6, 7: repeat (n + 1) add_char($urandom_range(1, 4), 4);
        8: begin
          // corrupt one byte of well-formed text
          repeat (n + 1) add_char($urandom_range(1, 4), 4);
          file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom());
        end
        9: begin
          // end the file inside a multibyte character
          repeat (n) add_char($urandom_range(1, 4), 4);
          len = $urandom_range(2, 4);
          add_char(len, $urandom_range(1, len - 1));
        end
        10: repeat (n + 1) append_byte(8'($urandom()));
        default: begin
          // partial or lone mark bytes
          case ($urandom_range(0, 3))
            0: file_q = '{BomUtf8B0};
            1: file_q = '{BomUtf8B0, BomUtf8B1};
            2: file_q = '{BomFf};
            default: file_q = '{BomFe};
          endcase
          repeat (n % 3) add_char($urandom_range(1, 4), 4);
        end
      endcase

      marker = (file_q.size() == 0) || ($urandom_range(0, 5) == 0);
      foreach (file_q[i]) begin
        if ($urandom_range(0, 15) == 0) begin
          beat.byte_value = 8'($urandom());
          beat.has_byte   = 1'b0;
          beat.last       = 1'b0;
          send_beat(beat, 1'b0, none);
        end
        beat.byte_value = file_q[i];
        beat.has_byte   = 1'b1;
        beat.last       = !marker && (i == file_q.size() - 1);
        send_beat(beat, 1'b0, none);
      end
      if (marker) begin
        beat.byte_value = 8'($urandom());
        beat.has_byte   = 1'b0;
        beat.last       = 1'b1;
        send_beat(beat, 1'b0, none);
      end
      if (files_sent % 30 == 0) hold_until_drained();
    end

    // Drain and finish
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("Summary: %0d beats in %0d files, random stalls on both sides.",
             beats_sent, files_sent);
    $display("Verdicts: utf8-mark %0d, utf16-le %0d, utf16-be %0d, utf8 %0d, ansi %0d",
             enc_seen[0], enc_seen[1], enc_seen[2], enc_seen[3], enc_seen[4]);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: stall pattern that switches among steady, choppy and bursty modes
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    sink_mode   = SinkSteady;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (sink_mode)
        SinkSteady: out_ready_i <= 1'b1;
        SinkChoppy: out_ready_i <= 1'($urandom_range(0, 1));
        default: begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 3) == 0) hold_left <= $urandom_range(1, 12);
        end
      endcase
    end
    if (cycle_cnt % 300 == 0) sink_mode <= sink_mode_e'($urandom_range(0, 2));
  end

  // Compare each taken verdict with the oldest queued one
  initial err_cnt = 0;
  initial enc_seen = '{0, 0, 0, 0, 0};

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: verdict with none queued: encoding %0d mark %0d", $time,
                   out_o.encoding, out_o.mark_length);
      end else begin
        want = verdict_q.pop_front();
        enc_seen[int'(want.encoding)]++;
        if (out_o.encoding !== want.encoding || out_o.mark_length !== want.mark_length) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: verdict mismatch: expected encoding %0d mark %0d, got %0d mark %0d",
                     $time, want.encoding, want.mark_length, out_o.encoding,
                     out_o.mark_length);
        end
      end
    end
  end

  // Timeout
  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
               verdict_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

`default_nettype wire
